/* hw/rtl/fbb_pkg.sv */
// ----------------------------------------------------------------------------
// fbb_pkg: shared types and constants for the 3x3 box blur
// Pixel and result words, controller-to-datapath commands, reciprocal table.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package fbb_pkg;

  localparam int MAX_FRAME = 1024;
  localparam int FRAME_W   = $clog2(MAX_FRAME) + 1;  // frame_size register
  localparam int COORD_W   = $clog2(MAX_FRAME);      // row / column
  localparam int ADDR_W    = $clog2(2 * MAX_FRAME);  // two line stores
  localparam int CHAN_W    = 16;
  localparam int ACC_W     = 20;                     // 9 * 65535 fits
  localparam int RECIP_W   = 25;
  localparam int RECIP_SH  = 24;
  localparam int PROD_W    = ACC_W + RECIP_W;

  // input word
  typedef struct packed {
    logic [CHAN_W-1:0] red_in;
    logic [CHAN_W-1:0] green_in;
    logic [CHAN_W-1:0] blue_in;
  } in_word_t;

  // result word
  typedef struct packed {
    logic [COORD_W-1:0] out_row;
    logic [COORD_W-1:0] out_col;
    logic [CHAN_W-1:0]  red_out;
    logic [CHAN_W-1:0]  green_out;
    logic [CHAN_W-1:0]  blue_out;
    logic               run_last;
  } out_word_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOAD,
    ST_SUM,
    ST_MUL,
    ST_OUT
  } state_e;

  // commands from controller to datapath
  typedef struct packed {
    logic               capture;   // take input word, access line store
    logic               load;      // shift window, insert new column
    logic               acc_en;
    logic               acc_first;
    logic [1:0]         row;       // window row summed this cycle
    logic [1:0]         col_lo;    // leftmost window column used
    logic               mul_en;
    logic [3:0]         num;       // pixel count, divisor
    logic               row_par;
    logic [COORD_W-1:0] col;
    logic [COORD_W-1:0] out_row;
    logic [COORD_W-1:0] out_col;
    logic               last;
  } cmd_t;

  // floor(2^24/d)+1: exact quotient for any 20-bit dividend, d one of 1, 2, 3, 4, 6, 9
  function automatic logic [RECIP_W-1:0] recip(input logic [3:0] d);
    logic [RECIP_W-1:0] m;
    case (d)
      4'd1:    m = 25'd16777217;
      4'd2:    m = 25'd8388609;
      4'd3:    m = 25'd5592406;
      4'd4:    m = 25'd4194305;
      4'd6:    m = 25'd2796203;
      4'd9:    m = 25'd1864136;
      default: m = '0;
    endcase
    return m;
  endfunction

endpackage

`default_nettype wire

/* hw/rtl/fbb_dp.sv */
// ----------------------------------------------------------------------------
// fbb_dp: box blur datapath
// Line stores, 3x3 window, row accumulators, reciprocal divide, result reg.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module fbb_dp (
  input  wire logic             clk_i,
  input  wire fbb_pkg::cmd_t    cmd_i,
  input  wire fbb_pkg::in_word_t in_data_i,
  output fbb_pkg::out_word_t    out_data_o
);

  fbb_pkg::in_word_t mem [2*fbb_pkg::MAX_FRAME];
  fbb_pkg::in_word_t rd_a_q, rd_b_q, px_q;
  fbb_pkg::in_word_t win_q [3][3];  // [column][row]

  logic [fbb_pkg::ADDR_W-1:0] addr_a, addr_b;
  logic [fbb_pkg::ACC_W-1:0]  acc_r_q, acc_g_q, acc_b_q;
  logic [fbb_pkg::ACC_W-1:0]  sum_r, sum_g, sum_b;
  logic [fbb_pkg::RECIP_W-1:0] m;
  logic [fbb_pkg::PROD_W-1:0] prod_r, prod_g, prod_b;
  fbb_pkg::out_word_t out_q;

  // row r-2 sits in the slot of r's parity, row r-1 in the other
  assign addr_a = {cmd_i.row_par, cmd_i.col};
  assign addr_b = {~cmd_i.row_par, cmd_i.col};

  // line store: read old rows, write new pixel
  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      rd_a_q       <= mem[addr_a];
      rd_b_q       <= mem[addr_b];
      mem[addr_a]  <= in_data_i;
      px_q         <= in_data_i;
    end
  end

  // window shift
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      win_q[0]    <= win_q[1];
      win_q[1]    <= win_q[2];
      win_q[2][0] <= rd_a_q;
      win_q[2][1] <= rd_b_q;
      win_q[2][2] <= px_q;
    end
  end

  // one window row per cycle, columns from col_lo on
  always_comb begin
    sum_r = cmd_i.acc_first ? '0 : acc_r_q;
    sum_g = cmd_i.acc_first ? '0 : acc_g_q;
    sum_b = cmd_i.acc_first ? '0 : acc_b_q;
    for (int dc = 0; dc < 3; dc++) begin
      if (2'(dc) >= cmd_i.col_lo) begin
        sum_r = sum_r + fbb_pkg::ACC_W'(win_q[dc][cmd_i.row].red_in);
        sum_g = sum_g + fbb_pkg::ACC_W'(win_q[dc][cmd_i.row].green_in);
        sum_b = sum_b + fbb_pkg::ACC_W'(win_q[dc][cmd_i.row].blue_in);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.acc_en) begin
      acc_r_q <= sum_r;
      acc_g_q <= sum_g;
      acc_b_q <= sum_b;
    end
  end

  // divide by multiplying with the reciprocal
  assign m      = fbb_pkg::recip(cmd_i.num);
  assign prod_r = fbb_pkg::PROD_W'(acc_r_q) * fbb_pkg::PROD_W'(m);
  assign prod_g = fbb_pkg::PROD_W'(acc_g_q) * fbb_pkg::PROD_W'(m);
  assign prod_b = fbb_pkg::PROD_W'(acc_b_q) * fbb_pkg::PROD_W'(m);

  // result register, holds while stalled
  always_ff @(posedge clk_i) begin
    if (cmd_i.mul_en) begin
      out_q.out_row   <= cmd_i.out_row;
      out_q.out_col   <= cmd_i.out_col;
      out_q.red_out   <= prod_r[fbb_pkg::RECIP_SH +: fbb_pkg::CHAN_W];
      out_q.green_out <= prod_g[fbb_pkg::RECIP_SH +: fbb_pkg::CHAN_W];
      out_q.blue_out  <= prod_b[fbb_pkg::RECIP_SH +: fbb_pkg::CHAN_W];
      out_q.run_last  <= cmd_i.last;
    end
  end

  assign out_data_o = out_q;

endmodule

`default_nettype wire

/* hw/rtl/fbb_ctrl.sv */
// ----------------------------------------------------------------------------
// fbb_ctrl: box blur controller
// Frame position, frame size register and the per-result sequencing.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module fbb_ctrl (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         in_valid_i,
  output logic                              in_stall_o,
  output logic                              out_valid_o,
  input  wire logic                         out_stall_i,
  input  wire logic                         cfg_valid_i,
  output logic                              cfg_ready_o,
  input  wire logic [fbb_pkg::FRAME_W-1:0]  cfg_data_i,
  output fbb_pkg::cmd_t                     cmd_o
);

  fbb_pkg::state_e state_q, state_d;
  logic [fbb_pkg::FRAME_W-1:0] frame_q;
  logic [fbb_pkg::COORD_W-1:0] row_q, row_d, col_q, col_d, n_m1;
  logic [1:0] di_q, di_d, dj_q, dj_d, k_q, k_d;
  logic [1:0] di_start, di_end, dj_start, dj_end;
  logic       row_last, col_last, any_out, advance;

  // effective size minus one: zero reads as 1, large values saturate
  always_comb begin
    if (frame_q == '0) begin
      n_m1 = '0;
    end else if (frame_q > fbb_pkg::FRAME_W'(fbb_pkg::MAX_FRAME)) begin
      n_m1 = fbb_pkg::COORD_W'(fbb_pkg::MAX_FRAME - 1);
    end else begin
      n_m1 = fbb_pkg::COORD_W'(frame_q - 1'b1);
    end
  end

  // offsets of emitted results back from the current pixel
  always_comb begin
    row_last = (row_q == n_m1);
    col_last = (col_q == n_m1);
    di_start = (row_last && row_q < 2) ? row_q[1:0] : 2'd2;
    dj_start = (col_last && col_q < 2) ? col_q[1:0] : 2'd2;
    di_end   = row_last ? 2'd0 : 2'd2;
    dj_end   = col_last ? 2'd0 : 2'd2;
    any_out  = (row_last || row_q >= 2) && (col_last || col_q >= 2);
  end

  always_comb begin
    state_d = state_q;
    di_d    = di_q;
    dj_d    = dj_q;
    k_d     = k_q;
    advance = 1'b0;
    cmd_o           = '0;
    cmd_o.row_par   = row_q[0];
    cmd_o.col       = col_q;
    cmd_o.row       = k_q;
    cmd_o.col_lo    = 2'd2 - dj_q;
    cmd_o.acc_first = (k_q == 2'd2 - di_q);
    cmd_o.num       = 4'(({2'b0, di_q} + 4'd1) * ({2'b0, dj_q} + 4'd1));
    cmd_o.out_row   = row_q - fbb_pkg::COORD_W'(di_q);
    cmd_o.out_col   = col_q - fbb_pkg::COORD_W'(dj_q);
    cmd_o.last      = (di_q == di_end) && (dj_q == dj_end);
    case (state_q)
      fbb_pkg::ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          state_d       = fbb_pkg::ST_LOAD;
        end
      end
      fbb_pkg::ST_LOAD: begin
        cmd_o.load = 1'b1;
        if (any_out) begin
          di_d    = di_start;
          dj_d    = dj_start;
          k_d     = 2'd2 - di_start;
          state_d = fbb_pkg::ST_SUM;
        end else begin
          advance = 1'b1;
          state_d = fbb_pkg::ST_IDLE;
        end
      end
      fbb_pkg::ST_SUM: begin
        cmd_o.acc_en = 1'b1;
        if (k_q == 2'd2) begin
          state_d = fbb_pkg::ST_MUL;
        end else begin
          k_d = k_q + 2'd1;
        end
      end
      fbb_pkg::ST_MUL: begin
        cmd_o.mul_en = 1'b1;
        state_d      = fbb_pkg::ST_OUT;
      end
      fbb_pkg::ST_OUT: begin
        if (!out_stall_i) begin
          if (dj_q != dj_end) begin
            dj_d    = dj_q - 2'd1;
            k_d     = 2'd2 - di_q;
            state_d = fbb_pkg::ST_SUM;
          end else if (di_q != di_end) begin
            di_d    = di_q - 2'd1;
            dj_d    = dj_start;
            k_d     = 2'd3 - di_q;
            state_d = fbb_pkg::ST_SUM;
          end else begin
            advance = 1'b1;
            state_d = fbb_pkg::ST_IDLE;
          end
        end
      end
      default: state_d = fbb_pkg::ST_IDLE;
    endcase
  end

  // raster position of the next pixel
  always_comb begin
    row_d = row_q;
    col_d = col_q;
    if (advance) begin
      if (col_last) begin
        col_d = '0;
        row_d = row_last ? '0 : row_q + 1'b1;
      end else begin
        col_d = col_q + 1'b1;
      end
    end
  end

  assign in_stall_o  = (state_q != fbb_pkg::ST_IDLE);
  assign cfg_ready_o = (state_q == fbb_pkg::ST_IDLE);
  assign out_valid_o = (state_q == fbb_pkg::ST_OUT);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= fbb_pkg::ST_IDLE;
      frame_q <= fbb_pkg::FRAME_W'(fbb_pkg::MAX_FRAME);
      row_q   <= '0;
      col_q   <= '0;
      di_q    <= '0;
      dj_q    <= '0;
      k_q     <= '0;
    end else begin
      state_q <= state_d;
      di_q    <= di_d;
      dj_q    <= dj_d;
      k_q     <= k_d;
      if (cfg_valid_i && cfg_ready_o) begin
        frame_q <= cfg_data_i;
        row_q   <= '0;
        col_q   <= '0;
      end else begin
        row_q <= row_d;
        col_q <= col_d;
      end
    end
  end

endmodule

`default_nettype wire

/* hw/rtl/forward_box_blur_3x3.sv */
// ----------------------------------------------------------------------------
// forward_box_blur_3x3: streaming 3x3 box blur of a square RGB frame
// Pixels enter in raster order; clipped window averages leave by row/column.
// ----------------------------------------------------------------------------
// Input channel: in_valid_i / in_stall_o carry one pixel word. Output channel:
// out_valid_o / out_stall_i carry result words; a pixel causes 0 to 9 results,
// the last flagged by run_last. Config channel: cfg_valid_i / cfg_ready_o
// write frame_size (1..1024) and restart the frame at pixel (0,0).
// Sequence: a pixel is taken in the idle state, the load state loads the
// window from the line store, then each result sums one window row per
// cycle (1 to 3 rows) in the sum state and passes the multiply state and
// the output state. The shared row adder is sequenced through these states.
// Reset: frame size 1024, position (0,0), no result pending. Line stores are
// not cleared; unwritten entries never feed a result.
// A stalled result holds its word; no new pixel is taken until all results
// of the current pixel have been delivered.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module forward_box_blur_3x3 (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        in_valid_i,
  output logic                             in_stall_o,
  input  wire fbb_pkg::in_word_t           in_data_i,
  output logic                             out_valid_o,
  input  wire logic                        out_stall_i,
  output fbb_pkg::out_word_t               out_data_o,
  input  wire logic                        cfg_valid_i,
  output logic                             cfg_ready_o,
  input  wire logic [fbb_pkg::FRAME_W-1:0] cfg_data_i
);

  fbb_pkg::cmd_t cmd;

  fbb_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_data_i  (cfg_data_i),
    .cmd_o       (cmd)
  );

  fbb_dp u_dp (
    .clk_i      (clk_i),
    .cmd_i      (cmd),
    .in_data_i  (in_data_i),
    .out_data_o (out_data_o)
  );

endmodule

`default_nettype wire
